FILE: hdl/dqp_pkg.sv
package dqp_pkg;

	localparam int HDR_LEN    = 12;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// header flag byte 2 fields
	localparam logic [7:0] QR_MASK     = 8'h80;
	localparam logic [7:0] OPCODE_MASK = 8'b0111_1000;
	localparam logic [7:0] TC_MASK     = 8'b0000_0010;
	localparam logic [7:0] OP_STATUS   = 8'b0001_0000;
	localparam logic [7:0] OP_NOTIFY   = 8'b0010_0000;
	localparam logic [7:0] OP_UPDATE   = 8'b0010_1000;

	localparam logic [1:0] KIND_NAME   = 2'd0;
	localparam logic [1:0] KIND_QUEST  = 2'd1;
	localparam logic [1:0] KIND_PACKET = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_LABEL    = 3'd2;
	localparam logic [2:0] ST_NAME     = 3'd3;
	localparam logic [2:0] ST_UNIMPL   = 3'd4;
	localparam logic [2:0] ST_RESPONSE = 3'd5;

	localparam logic CFG_QUESTION_LIMIT = 1'b0;
	localparam logic CFG_NAME_LIMIT     = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_byte;
		logic        is_length_byte;
		logic [7:0]  question_index;
		logic [15:0] query_type;
		logic [15:0] query_class;
		logic [2:0]  status;
		logic [15:0] packet_id;
		logic [15:0] header_flags;
		logic [15:0] question_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [7:0] question_limit;
		logic [7:0] name_limit;
	} cfg_t;

endpackage

FILE: hdl/dqp_ifs.sv
interface dqp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       is_last;
	modport source (output valid, byte_value, is_last, input ready);
	modport sink (input valid, byte_value, is_last, output ready);
endinterface

interface dqp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  name_byte;
	logic        is_length_byte;
	logic [7:0]  question_index;
	logic [15:0] query_type;
	logic [15:0] query_class;
	logic [2:0]  status;
	logic [15:0] packet_id;
	logic [15:0] header_flags;
	logic [15:0] question_count;
	logic        last;
	modport source (output valid, kind, name_byte, is_length_byte, question_index,
		query_type, query_class, status, packet_id, header_flags, question_count, last,
		input ready);
	modport sink (input valid, kind, name_byte, is_length_byte, question_index,
		query_type, query_class, status, packet_id, header_flags, question_count, last,
		output ready);
endinterface

interface dqp_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/dns_query_parser_core.sv
// channel | role   | payload                                    | transfer
// pkt     | sink   | byte_value, is_last                        | valid & ready
// res     | source | kind, name_byte, ..., question_count, last | valid & ready
// cfg     | sink   | index (0 question_limit, 1 name_limit), data | valid & ready, always ready
//
// A byte per cycle while pkt.ready is high; bytes are registered before their results are queued.
// A byte yields at most two results (one plus packet done on the last byte).
// pkt.ready drops while the 8-entry result queue holds more than four results.
// arst_n clears parse state, queue pointers and the registers to 4 and 255.
// res stalls only back-pressure pkt through the queue; nothing is dropped.
module dns_query_parser_core
	import dqp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	dqp_byte_if.sink      pkt,
	dqp_result_if.source  res,
	dqp_cfg_if.sink       cfg
);

	cfg_t                cfg_q;
	logic [FIFO_CW-1:0]  count;
	logic                room;
	push_t               push;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.question_limit <= 8'd4;
			cfg_q.name_limit     <= 8'd255;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_QUESTION_LIMIT: cfg_q.question_limit <= cfg.data;
				CFG_NAME_LIMIT:     cfg_q.name_limit     <= cfg.data;
				default: ;
			endcase
		end
	end

	// room for the byte in flight plus the new one, two results each
	assign room = count <= FIFO_CW'(FIFO_DEPTH - 4);

	dqp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.room   (room),
		.cfg    (cfg_q),
		.push   (push)
	);

	dqp_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.count  (count),
		.res    (res)
	);

endmodule

FILE: hdl/dqp_parser.sv
module dqp_parser
	import dqp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dqp_byte_if.sink   pkt,
	input  logic       room,
	input  cfg_t       cfg,
	output push_t      push
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_LEN    = 3'd1;
	localparam logic [2:0] PH_LABEL  = 3'd2;
	localparam logic [2:0] PH_SKIP   = 3'd3;
	localparam logic [2:0] PH_FIELDS = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [2:0]  phase_q, nx_phase;
	logic [3:0]  pos_q, nx_pos;
	logic [47:0] hdr_q, nx_hdr;
	logic [7:0]  qdone_q, nx_qdone;
	logic [7:0]  lrem_q, nx_lrem;
	logic [7:0]  nused_q, nx_nused;
	logic [23:0] acc_q, nx_acc;
	logic [2:0]  err_q, nx_err;

	logic [7:0]  f0, op;
	logic [8:0]  used;
	logic [15:0] wanted;
	logic        no_q;
	logic [8:0]  qdone_inc;
	logic        has_a;
	result_t     res_a, res_done;

	assign pkt.ready = room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= pkt.valid & pkt.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid & pkt.ready) begin
			byte_s1 <= pkt.byte_value;
			last_s1 <= pkt.is_last;
		end
	end

	assign f0        = hdr_q[31:24];
	assign op        = f0 & OPCODE_MASK;
	assign used      = {1'b0, nused_q} + 9'd1 + {1'b0, byte_s1};
	assign wanted    = (hdr_q[15:0] < {8'd0, cfg.question_limit}) ? hdr_q[15:0]
		: {8'd0, cfg.question_limit};
	assign no_q      = (hdr_q[15:0] == 16'd0) || (cfg.question_limit == 8'd0);
	assign qdone_inc = {1'b0, qdone_q} + 9'd1;

	always_comb begin
		nx_phase = phase_q;
		nx_pos   = pos_q;
		nx_hdr   = hdr_q;
		nx_qdone = qdone_q;
		nx_lrem  = lrem_q;
		nx_nused = nused_q;
		nx_acc   = acc_q;
		nx_err   = err_q;
		has_a    = 1'b0;
		res_a    = '0;
		res_done = '0;
		push     = '0;
		if (v_s1) begin
			case (phase_q)
				PH_HEADER: begin
					case (pos_q)
						4'd0: nx_hdr[47:40] = byte_s1;
						4'd1: nx_hdr[39:32] = byte_s1;
						4'd2: nx_hdr[31:24] = byte_s1;
						4'd3: nx_hdr[23:16] = byte_s1;
						4'd4: nx_hdr[15:8]  = byte_s1;
						4'd5: nx_hdr[7:0]   = byte_s1;
						default: ;
					endcase
					nx_pos = pos_q + 4'd1;
					if (pos_q == 4'(HDR_LEN - 1)) begin
						if ((f0 & QR_MASK) != 8'd0)
							nx_err = ST_RESPONSE;
						else if ((f0 & TC_MASK) != 8'd0 || op == OP_STATUS
							|| op == OP_NOTIFY || op == OP_UPDATE)
							nx_err = ST_UNIMPL;
						if (nx_err != ST_OK || no_q)
							nx_phase = PH_DONE;
						else
							nx_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					if (used > {1'b0, cfg.name_limit}) begin
						// over the limit: a zero terminator fails at once, else skip the label and report once it is complete
						if (byte_s1 == 8'd0) begin
							nx_err   = ST_NAME;
							nx_phase = PH_DONE;
						end else begin
							nx_lrem  = byte_s1;
							nx_phase = PH_SKIP;
						end
					end else begin
						has_a                = 1'b1;
						res_a.kind           = KIND_NAME;
						res_a.name_byte      = byte_s1;
						res_a.is_length_byte = 1'b1;
						res_a.question_index = qdone_q;
						nx_nused             = used[7:0];
						if (byte_s1 == 8'd0) begin
							nx_phase = PH_FIELDS;
							nx_pos   = 4'd0;
							nx_acc   = '0;
						end else begin
							nx_lrem  = byte_s1;
							nx_phase = PH_LABEL;
						end
					end
				end
				PH_LABEL: begin
					has_a                = 1'b1;
					res_a.kind           = KIND_NAME;
					res_a.name_byte      = byte_s1;
					res_a.question_index = qdone_q;
					nx_lrem              = lrem_q - 8'd1;
					if (lrem_q == 8'd1)
						nx_phase = PH_LEN;
				end
				PH_SKIP: begin
					nx_lrem = lrem_q - 8'd1;
					if (lrem_q == 8'd1) begin
						nx_err   = ST_NAME;
						nx_phase = PH_DONE;
					end
				end
				PH_FIELDS: begin
					nx_acc = {acc_q[15:0], byte_s1};
					nx_pos = pos_q + 4'd1;
					if (pos_q == 4'd3) begin
						has_a                = 1'b1;
						res_a.kind           = KIND_QUEST;
						res_a.question_index = qdone_q;
						res_a.query_type     = acc_q[23:8];
						res_a.query_class    = {acc_q[7:0], byte_s1};
						nx_qdone             = qdone_inc[7:0];
						nx_nused             = 8'd0;
						nx_pos               = 4'd0;
						nx_phase = ({7'd0, qdone_inc} >= wanted) ? PH_DONE : PH_LEN;
					end
				end
				default: ;
			endcase

			if (last_s1) begin
				case (nx_phase)
					PH_HEADER, PH_LEN, PH_FIELDS: nx_err = ST_SHORT;
					PH_LABEL, PH_SKIP:            nx_err = ST_LABEL;
					default: ;
				endcase
				res_done.kind           = KIND_PACKET;
				res_done.question_index = nx_qdone;
				res_done.status         = nx_err;
				res_done.packet_id      = nx_hdr[47:32];
				res_done.header_flags   = nx_hdr[31:16];
				res_done.question_count = nx_hdr[15:0];
				res_done.last           = 1'b1;
				nx_phase = PH_HEADER;
				nx_pos   = 4'd0;
				nx_hdr   = '0;
				nx_qdone = 8'd0;
				nx_lrem  = 8'd0;
				nx_nused = 8'd0;
				nx_acc   = '0;
				nx_err   = ST_OK;
			end

			push.n  = {1'b0, has_a} + {1'b0, last_s1};
			push.r0 = has_a ? res_a : res_done;
			push.r1 = res_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 4'd0;
			hdr_q   <= '0;
			qdone_q <= 8'd0;
			lrem_q  <= 8'd0;
			nused_q <= 8'd0;
			acc_q   <= '0;
			err_q   <= ST_OK;
		end else begin
			phase_q <= nx_phase;
			pos_q   <= nx_pos;
			hdr_q   <= nx_hdr;
			qdone_q <= nx_qdone;
			lrem_q  <= nx_lrem;
			nused_q <= nx_nused;
			acc_q   <= nx_acc;
			err_q   <= nx_err;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |=> (phase_q == PH_HEADER && pos_q == 4'd0 && err_q == ST_OK))
		else $error("parse state not cleared after packet end");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (qdone_q == 8'd0 && nused_q == 8'd0))
		else $error("question state live during header");

endmodule

FILE: hdl/dqp_result_fifo.sv
module dqp_result_fifo
	import dqp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  push_t               push,
	output logic [FIFO_CW-1:0]  count,
	dqp_result_if.source        res
);

	result_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q, rd_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;
	result_t              head;

	assign pop   = res.valid & res.ready;
	assign count = count_q;
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem[wr_q + FIFO_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(push.n);
			rd_q    <= rd_q + FIFO_AW'(pop);
			count_q <= count_q + FIFO_CW'(push.n) - FIFO_CW'(pop);
		end
	end

	assign res.valid          = count_q != '0;
	assign res.kind           = head.kind;
	assign res.name_byte      = head.name_byte;
	assign res.is_length_byte = head.is_length_byte;
	assign res.question_index = head.question_index;
	assign res.query_type     = head.query_type;
	assign res.query_class    = head.query_class;
	assign res.status         = head.status;
	assign res.packet_id      = head.packet_id;
	assign res.header_flags   = head.header_flags;
	assign res.question_count = head.question_count;
	assign res.last           = head.last;

	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) + 32'(push.n)) <= FIFO_DEPTH)
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd0 && !pop) |=> $stable(count_q))
		else $error("result queue count moved without transfer");

endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dqp_pkg::*;

	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASES       = 9;
	localparam int PHASE_BYTES  = 110;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTED  = 100;

	typedef enum logic [2:0] {
		PARSE_HEADER, PARSE_LENGTH, PARSE_LABEL, PARSE_SKIP, PARSE_FIELDS, PARSE_DONE
	} parse_phase_t;

	// Predicts the parser's result stream from accepted packet bytes and
	// compares what the block delivers against it.
	class dns_result_scoreboard;
		result_t      expected_results[$];
		logic [7:0]   question_limit = 8'd4;
		logic [7:0]   name_limit = 8'd255;
		parse_phase_t phase;
		logic [3:0]   position;
		logic [47:0]  header;
		logic [7:0]   questions_done;
		logic [7:0]   label_left;
		logic [7:0]   name_used;
		logic [31:0]  fields;
		logic [2:0]   verdict;
		int           errors;
		int           results_seen;
		int           packets;
		int           questions;
		int           name_bytes;
		int           status_count[8];

		function new();
			clear_packet();
		endfunction

		function void clear_packet();
			phase = PARSE_HEADER;
			position = '0;
			header = '0;
			questions_done = '0;
			label_left = '0;
			name_used = '0;
			fields = '0;
			verdict = ST_OK;
		endfunction

		function void set_limit(logic idx, logic [7:0] value);
			if (idx == CFG_QUESTION_LIMIT)
				question_limit = value;
			else
				name_limit = value;
		endfunction

		function int wanted_questions();
			int qd;
			qd = int'(header[15:0]);
			return (qd < int'(question_limit)) ? qd : int'(question_limit);
		endfunction

		function void note_byte(logic [7:0] b, logic is_last);
			result_t r;
			int      used;
			logic [7:0] f0;
			case (phase)
				PARSE_HEADER: begin
					if (position < 6)
						header[(5 - int'(position)) * 8 +: 8] = b;
					position++;
					if (position >= 12) begin
						f0 = header[31:24];
						if ((f0 & QR_MASK) != 0)
							verdict = ST_RESPONSE;
						else if ((f0 & TC_MASK) != 0 || (f0 & OPCODE_MASK) == OP_STATUS ||
								(f0 & OPCODE_MASK) == OP_NOTIFY ||
								(f0 & OPCODE_MASK) == OP_UPDATE)
							verdict = ST_UNIMPL;
						phase = (verdict != ST_OK || wanted_questions() == 0) ?
							PARSE_DONE : PARSE_LENGTH;
					end
				end
				PARSE_LENGTH: begin
					used = int'(name_used) + 1 + int'(b);
					if (used > int'(name_limit)) begin
						// length byte not emitted; a zero terminator fails at once
						if (b == 0) begin
							verdict = ST_NAME;
							phase = PARSE_DONE;
						end else begin
							label_left = b;
							phase = PARSE_SKIP;
						end
					end else begin
						r = '0;
						r.kind = KIND_NAME;
						r.name_byte = b;
						r.is_length_byte = 1'b1;
						r.question_index = questions_done;
						expected_results.push_back(r);
						name_bytes++;
						name_used = used[7:0];
						if (b == 0) begin
							phase = PARSE_FIELDS;
							position = '0;
							fields = '0;
						end else begin
							label_left = b;
							phase = PARSE_LABEL;
						end
					end
				end
				PARSE_LABEL: begin
					r = '0;
					r.kind = KIND_NAME;
					r.name_byte = b;
					r.question_index = questions_done;
					expected_results.push_back(r);
					name_bytes++;
					label_left--;
					if (label_left == 0)
						phase = PARSE_LENGTH;
				end
				PARSE_SKIP: begin
					label_left--;
					if (label_left == 0) begin
						verdict = ST_NAME;
						phase = PARSE_DONE;
					end
				end
				PARSE_FIELDS: begin
					fields = {fields[23:0], b};
					position++;
					if (position >= 4) begin
						r = '0;
						r.kind = KIND_QUEST;
						r.question_index = questions_done;
						r.query_type = fields[31:16];
						r.query_class = fields[15:0];
						expected_results.push_back(r);
						questions++;
						questions_done++;
						name_used = '0;
						position = '0;
						phase = (int'(questions_done) >= wanted_questions()) ?
							PARSE_DONE : PARSE_LENGTH;
					end
				end
				default: ;
			endcase

			if (is_last) begin
				case (phase)
					PARSE_HEADER, PARSE_LENGTH, PARSE_FIELDS: verdict = ST_SHORT;
					PARSE_LABEL, PARSE_SKIP: verdict = ST_LABEL;
					default: ;
				endcase
				r = '0;
				r.kind = KIND_PACKET;
				r.question_index = questions_done;
				r.status = verdict;
				r.packet_id = header[47:32];
				r.header_flags = header[31:16];
				r.question_count = header[15:0];
				r.last = 1'b1;
				expected_results.push_back(r);
				packets++;
				status_count[verdict]++;
				clear_packet();
			end
		endfunction

		task report(string msg);
			errors++;
			// keep the log readable when a whole stream goes wrong
			if (errors <= MAX_PRINTED)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task compare_field(string field, logic [15:0] got, logic [15:0] want, int n);
			if (got !== want)
				report($sformatf("result %0d %s got %h expected %h", n, field, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result kind %0d arrived with nothing expected", got.kind));
				return;
			end
			want = expected_results.pop_front();
			compare_field("kind", 16'(got.kind), 16'(want.kind), results_seen);
			compare_field("name_byte", 16'(got.name_byte), 16'(want.name_byte),
				results_seen);
			compare_field("is_length_byte", 16'(got.is_length_byte),
				16'(want.is_length_byte), results_seen);
			compare_field("question_index", 16'(got.question_index),
				16'(want.question_index), results_seen);
			compare_field("query_type", got.query_type, want.query_type, results_seen);
			compare_field("query_class", got.query_class, want.query_class, results_seen);
			compare_field("status", 16'(got.status), 16'(want.status), results_seen);
			compare_field("packet_id", got.packet_id, want.packet_id, results_seen);
			compare_field("header_flags", got.header_flags, want.header_flags, results_seen);
			compare_field("question_count", got.question_count, want.question_count,
				results_seen);
			compare_field("last", 16'(got.last), 16'(want.last), results_seen);
			results_seen++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on = 1'b1;
	bit   hold_req = 1'b0;
	int   stall_cycles = 0;

	dns_result_scoreboard sb = new();

	dqp_byte_if   pkt_if();
	dqp_result_if res_if();
	dqp_cfg_if    cfg_if();

	dns_query_parser_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always #2 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n || (pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				res_if.ready <= !(idle_on && $urandom_range(99) < 32);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got.kind = res_if.kind;
			got.name_byte = res_if.name_byte;
			got.is_length_byte = res_if.is_length_byte;
			got.question_index = res_if.question_index;
			got.query_type = res_if.query_type;
			got.query_class = res_if.query_class;
			got.status = res_if.status;
			got.packet_id = res_if.packet_id;
			got.header_flags = res_if.header_flags;
			got.question_count = res_if.question_count;
			got.last = res_if.last;
			sb.check_result(got);
		end
	end

	// called just after a falling edge; returns just after a falling edge
	task automatic send_byte(logic [7:0] b, logic is_last);
		while (idle_on && $urandom_range(99) < 32) begin
			pkt_if.valid <= 1'b0;
			@(negedge clk);
		end
		pkt_if.valid <= 1'b1;
		pkt_if.byte_value <= b;
		pkt_if.is_last <= is_last;
		do @(posedge clk); while (pkt_if.ready !== 1'b1);
		sb.note_byte(b, is_last);
		@(negedge clk);
	endtask

	task automatic send_packet(logic [7:0] q[$]);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	task automatic write_reg(logic idx, logic [7:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		sb.set_limit(idx, value);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every expected result, then for bytes that produce none
	task automatic settle();
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic void put_header(ref logic [7:0] q[$], input logic [15:0] id,
			input logic [15:0] flags, input logic [15:0] qd);
		q = {id[15:8], id[7:0], flags[15:8], flags[7:0], qd[15:8], qd[7:0]};
		repeat (6) q.push_back(8'($urandom));
	endfunction

	function automatic void make_packet(ref logic [7:0] q[$]);
		logic [15:0] flags;
		logic [15:0] qd;
		logic [7:0]  op;
		int          nq;
		int          len;
		int          r;
		int          cut;
		flags = 16'($urandom);
		// mostly plain queries, so parsing gets past the header
		if ($urandom_range(99) < 80) begin
			flags[15] = 1'b0;
			flags[9] = 1'b0;
			op = flags[15:8] & OPCODE_MASK;
			if (op == OP_STATUS || op == OP_NOTIFY || op == OP_UPDATE)
				flags[14:11] = 4'd0;
		end
		r = $urandom_range(99);
		if (r < 70)
			qd = 16'($urandom_range(1, 4));
		else if (r < 85)
			qd = 16'($urandom_range(0, 8));
		else
			qd = 16'($urandom);
		put_header(q, 16'($urandom), flags, qd);
		nq = (qd < 6) ? int'(qd) : $urandom_range(1, 6);
		repeat (nq) begin
			repeat ($urandom_range(0, 3)) begin
				r = $urandom_range(99);
				if (r < 92)
					len = $urandom_range(1, 6);
				else if (r < 99)
					len = $urandom_range(7, 63);
				else
					len = $urandom_range(64, 255);
				q.push_back(8'(len));
				repeat (len) q.push_back(8'($urandom));
			end
			q.push_back(8'd0);
			repeat (4) q.push_back(8'($urandom));
		end
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
		if ($urandom_range(99) < 12) begin
			cut = $urandom_range(1, q.size());
			while (q.size() > cut)
				void'(q.pop_back());
		end
	endfunction

	initial begin
		logic [7:0] pkt_q[$];
		int         phase_bytes;
		int         qtab[PHASES] = '{1, 0, 255, 2, 4, 3, 255, 1, 2};
		int         ntab[PHASES] = '{255, 255, 1, 12, 9, 6, 255, 30, 20};

		pkt_if.valid <= 1'b0;
		pkt_if.byte_value <= '0;
		pkt_if.is_last <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_QUESTION_LIMIT;
		cfg_if.data <= '0;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// header cut short
		pkt_q = {8'hFF, 8'hFF, 8'h81};
		send_packet(pkt_q);
		// response with opcode update and truncation: response wins
		put_header(pkt_q, 16'h0000, 16'hAA00, 16'h0001);
		pkt_q.push_back(8'h00);
		send_packet(pkt_q);
		// notify opcode
		put_header(pkt_q, 16'hFFFF, 16'h2000, 16'h0003);
		send_packet(pkt_q);
		// query whose packet ends right after the header
		put_header(pkt_q, 16'h1234, 16'h0100, 16'h0001);
		send_packet(pkt_q);
		// no questions, trailing byte ignored
		put_header(pkt_q, 16'h5A5A, 16'h7DFF, 16'h0000);
		pkt_q.push_back(8'hFF);
		send_packet(pkt_q);
		// one full question, then a label cut off by the end of the packet
		put_header(pkt_q, 16'hA5C3, 16'h0100, 16'h0002);
		pkt_q = {pkt_q, 8'd3, 8'h61, 8'h62, 8'h63, 8'd0, 8'h00, 8'h01, 8'hFF, 8'hFE,
			8'd5, 8'h78};
		send_packet(pkt_q);
		// end on the name terminator, before type and class
		put_header(pkt_q, 16'h0F0F, 16'h0000, 16'h0001);
		pkt_q = {pkt_q, 8'd1, 8'h7A, 8'd0};
		send_packet(pkt_q);
		pkt_if.valid <= 1'b0;
		settle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_QUESTION_LIMIT, 8'(qtab[p]));
			write_reg(CFG_NAME_LIMIT, 8'(ntab[p]));
			idle_on = (p != 5);
			if (p == 3)
				hold_req = 1'b1;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				make_packet(pkt_q);
				send_packet(pkt_q);
				phase_bytes += pkt_q.size();
			end
			pkt_if.valid <= 1'b0;
			settle();
		end

		if (sb.expected_results.size() != 0)
			sb.report($sformatf("%0d expected results never arrived",
				sb.expected_results.size()));

		$display("Covered %0d packets, %0d questions, %0d name bytes, %0d results checked",
			sb.packets, sb.questions, sb.name_bytes, sb.results_seen);
		$display("Packet status: ok %0d, short %0d, label %0d, name %0d, unimpl %0d, resp %0d",
			sb.status_count[ST_OK], sb.status_count[ST_SHORT], sb.status_count[ST_LABEL],
			sb.status_count[ST_NAME], sb.status_count[ST_UNIMPL],
			sb.status_count[ST_RESPONSE]);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/dqp_pkg.sv
hdl/dqp_ifs.sv
hdl/dqp_parser.sv
hdl/dqp_result_fifo.sv
hdl/dns_query_parser_core.sv
tb/testbench.sv
